@@ sv/icy_metadata_demuxer_unit_assert.svh @@
// Assertion macros for the ICY metadata demuxer checker.
// Depends on nothing; included by the checker file.
`ifndef ICY_METADATA_DEMUXER_UNIT_ASSERT_SVH
`define ICY_METADATA_DEMUXER_UNIT_ASSERT_SVH
`define ICY_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m lbl");
`define ICY_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m lbl");
`endif

@@ sv/icy_pkg.sv @@
// Shared types and constants of the ICY metadata demuxer.
// No dependencies.
package icy_pkg;
  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_ARTIST = 2'd1;
  localparam logic [1:0] KIND_TITLE  = 2'd2;

  typedef enum logic [1:0] {SEC_AUDIO, SEC_LEN, SEC_BODY} sec_t;
  typedef enum logic [1:0] {PH_SEEK, PH_FIRST, PH_CAPTURE, PH_DONE} phase_t;

  // queue entry from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  localparam logic [1:0] OP_AUDIO  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CMP, BK_COPY, BK_SEP, BK_DASH, BK_ARTIST, BK_TITLE
  } bk_state_t;

  function automatic logic [7:0] key_char(input logic [3:0] i);
    case (i)
      4'd0: key_char = "S";
      4'd1: key_char = "t";
      4'd2: key_char = "r";
      4'd3: key_char = "e";
      4'd4: key_char = "a";
      4'd5: key_char = "m";
      4'd6: key_char = "T";
      4'd7: key_char = "i";
      4'd8: key_char = "t";
      4'd9: key_char = "l";
      4'd10: key_char = "e";
      4'd11: key_char = "=";
      default: key_char = 8'h00;
    endcase
  endfunction
endpackage

@@ sv/icy_metadata_demuxer_unit.sv @@
// ICY metadata demuxer top level: APB register, front end, command queue, back end.
// Audio bytes pass the front-end command register, then the back-end output register;
// one item per cycle unless held by output back-pressure or a title emission. Compare,
// copy, separator search and emit each walk the title store one entry a cycle.
// In an emission, intake takes one more byte into the queue, then stalls until it ends.
// Reset: synchronous, clears interval, parse state and the last shown title.
module icy_metadata_demuxer_unit
  import icy_pkg::*;
#(
  parameter int TITLE_CHARS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic        out_last
);
  logic [15:0] meta_interval;
  logic        cfg_we, cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr == 2'd0;
  assign prdata = (paddr == 2'd0) ? {16'd0, meta_interval} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) meta_interval <= 16'd0;
    else if (cfg_we) meta_interval <= pwdata[15:0];
  end

  icy_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_val(pwdata[15:0]),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(byte_in),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  icy_back #(.TITLE_CHARS(TITLE_CHARS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_data(out_data), .out_last(out_last));
endmodule

@@ sv/icy_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/icy_front.sv @@
// Front end: stream sectioning, key search and value scrubbing.
// Depends on icy_pkg; emits commands into the queue.
module icy_front
  import icy_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_val,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  logic [15:0] meta_interval, audio_left;
  logic [11:0] meta_left;
  sec_t        section;
  phase_t      phase;
  logic [3:0]  key_matched;
  logic [7:0]  quote_kind;
  logic        quote_held;
  logic [1:0]  cmd_cnt;
  cmd_t        cmd_a, cmd_b;

  sec_t        section_next;
  phase_t      phase_next;
  logic [15:0] audio_left_next;
  logic [11:0] meta_left_next;
  logic [3:0]  key_next;
  logic [7:0]  quote_next;
  logic        held_next;
  logic [1:0]  n_next;
  cmd_t        a_next, b_next;
  logic        take;

  assign in_ready  = (cmd_cnt == 2'd0) || (cmd_cnt == 2'd1 && cmd_ready);
  assign take      = in_valid && in_ready;
  assign cmd_valid = cmd_cnt != 2'd0;
  assign cmd       = cmd_a;

  always_comb begin
    logic [7:0] c;
    logic       is_last;
    logic       app1, app2;
    logic [7:0] d1, d2;
    c = in_byte;
    section_next = section;
    phase_next = phase;
    audio_left_next = audio_left;
    meta_left_next = meta_left;
    key_next = key_matched;
    quote_next = quote_kind;
    held_next = quote_held;
    n_next = 2'd0;
    a_next = '{op: OP_AUDIO, data: c};
    b_next = '{op: OP_FINISH, data: 8'h00};
    app1 = 1'b0;
    app2 = 1'b0;
    d1 = c;
    d2 = c;
    is_last = 1'b0;
    if (meta_interval == 16'd0) begin
      n_next = 2'd1;
    end else if (section == SEC_AUDIO && audio_left != 16'd0) begin
      n_next = 2'd1;
      audio_left_next = audio_left - 16'd1;
      if (audio_left == 16'd1) begin
        section_next = SEC_LEN;
      end
    end else if (section != SEC_BODY) begin
      meta_left_next = {c, 4'd0};
      key_next = 4'd0;
      phase_next = PH_SEEK;
      quote_next = 8'h00;
      held_next = 1'b0;
      n_next = 2'd1;
      a_next = '{op: OP_CLEAR, data: 8'h00};
      if (c == 8'h00) begin
        audio_left_next = meta_interval;
        section_next = SEC_AUDIO;
      end else begin
        section_next = SEC_BODY;
      end
    end else begin
      is_last = meta_left == 12'd1;
      case (phase)
        PH_SEEK: begin
          if (key_matched < 4'd12 && c == key_char(key_matched)) begin
            key_next = key_matched + 4'd1;
          end else begin
            key_next = (c == key_char(4'd0)) ? 4'd1 : 4'd0;
          end
          if (key_next == 4'd12) begin
            phase_next = PH_FIRST;
          end
        end
        PH_FIRST: begin
          phase_next = PH_CAPTURE;
          if (c == 8'h27 || c == 8'h22) begin
            quote_next = c;
          end else begin
            quote_next = 8'h00;
            if (c == ";") begin
              phase_next = PH_DONE;
            end else begin
              app1 = 1'b1;
            end
          end
        end
        PH_CAPTURE: begin
          if (quote_kind != 8'h00) begin
            if (quote_held) begin
              held_next = 1'b0;
              if (c == ";") begin
                phase_next = PH_DONE;
              end else begin
                app1 = 1'b1;
                d1 = quote_kind;
                if (c == quote_kind) begin
                  held_next = 1'b1;
                end else begin
                  app2 = 1'b1;
                end
              end
            end else if (c == quote_kind) begin
              held_next = 1'b1;
            end else begin
              app1 = 1'b1;
            end
          end else if (c == ";") begin
            phase_next = PH_DONE;
          end else begin
            app1 = 1'b1;
          end
        end
        default: ;
      endcase
      if (app1 && app2) begin
        n_next = 2'd2;
        a_next = '{op: OP_APPEND, data: d1};
        b_next = '{op: OP_APPEND, data: d2};
      end else if (app1) begin
        n_next = 2'd1;
        a_next = '{op: OP_APPEND, data: d1};
      end
      if (is_last) begin
        // finish replaces parse state
        if (n_next == 2'd0) begin
          a_next = '{op: OP_FINISH, data: {7'd0, phase != PH_SEEK}};
          n_next = 2'd1;
        end else if (n_next == 2'd1) begin
          b_next = '{op: OP_FINISH, data: {7'd0, phase != PH_SEEK}};
          n_next = 2'd2;
        end else begin
          n_next = 2'd3;
        end
        meta_left_next = 12'd0;
        audio_left_next = meta_interval;
        section_next = SEC_AUDIO;
        phase_next = PH_SEEK;
        key_next = 4'd0;
        quote_next = 8'h00;
        held_next = 1'b0;
      end else begin
        meta_left_next = meta_left - 12'd1;
      end
    end
  end

  // three-deep staging: a, b, and a pending finish flag
  logic fin_pend, fin_flag;
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval <= 16'd0;
      audio_left <= 16'd0;
      meta_left <= 12'd0;
      section <= SEC_AUDIO;
      phase <= PH_SEEK;
      key_matched <= 4'd0;
      quote_kind <= 8'h00;
      quote_held <= 1'b0;
      cmd_cnt <= 2'd0;
      fin_pend <= 1'b0;
      fin_flag <= 1'b0;
    end else if (cfg_we) begin
      meta_interval <= cfg_val;
      audio_left <= cfg_val;
      section <= SEC_AUDIO;
      meta_left <= 12'd0;
      phase <= PH_SEEK;
      key_matched <= 4'd0;
      quote_kind <= 8'h00;
      quote_held <= 1'b0;
    end else if (take) begin
      section <= section_next;
      phase <= phase_next;
      audio_left <= audio_left_next;
      meta_left <= meta_left_next;
      key_matched <= key_next;
      quote_kind <= quote_next;
      quote_held <= held_next;
      cmd_a <= a_next;
      cmd_b <= b_next;
      cmd_cnt <= (n_next == 2'd3) ? 2'd2 : n_next;
      fin_pend <= n_next == 2'd3;
      fin_flag <= phase != PH_SEEK;
    end else if (cmd_valid && cmd_ready) begin
      cmd_a <= cmd_b;
      if (fin_pend) begin
        cmd_b <= '{op: OP_FINISH, data: {7'd0, fin_flag}};
        fin_pend <= 1'b0;
      end else begin
        cmd_cnt <= cmd_cnt - 2'd1;
      end
    end
  end
endmodule

@@ sv/icy_back.sv @@
// Back end: title store, compare with last shown title, split and emit.
// Depends on icy_pkg and icy_ram.
module icy_back
  import icy_pkg::*;
#(
  parameter int TITLE_CHARS = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_last
);
  localparam int AW = $clog2(TITLE_CHARS + 1);
  localparam logic [AW-1:0] CAP = AW'(TITLE_CHARS);

  bk_state_t state, state_next;
  logic [AW-1:0] title_count, kept_count, shown_count, idx, sep_at;
  logic          sep_found, full, done_cap, pv;
  logic [7:0]    p1, p2;

  logic          t_we, s_we;
  logic [AW-1:0] t_wa, t_ra;
  logic [7:0]    t_wd, t_rd, s_rd;

  icy_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_title (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  icy_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_shown (
    .clk(clk), .we(s_we), .waddr(pv ? idx - AW'(1) : idx), .wdata(t_rd),
    .raddr(t_ra), .rdata(s_rd));

  logic [7:0] ch;
  assign ch = (cmd.data >= 8'h20 && cmd.data < 8'h7F) ? cmd.data : "?";
  logic oslot;
  assign oslot = !out_valid || out_ready;

  assign cmd_ready = (state == BK_IDLE) && (cmd.op != OP_AUDIO || oslot);
  assign t_we = cmd_valid && cmd_ready && cmd.op == OP_APPEND && !full && !done_cap;
  assign t_wa = title_count;
  assign t_wd = ch;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:
        if (cmd_valid && cmd.op == OP_FINISH && cmd.data[0] && kept_count != '0) begin
          state_next = BK_CMP;
        end
      BK_CMP:
        if (pv && (idx > shown_count || t_rd != s_rd)) state_next = BK_COPY;
        else if (idx == kept_count && pv && kept_count == shown_count) state_next = BK_IDLE;
        else if (idx > kept_count) state_next = BK_COPY;
      BK_COPY: if (pv && idx == kept_count) state_next = BK_SEP;
      BK_SEP:
        if (sep_found || idx == kept_count) state_next = sep_found ?
          ((sep_at == '0) ? BK_TITLE : BK_ARTIST) : BK_DASH;
      BK_DASH: if (oslot) state_next = BK_TITLE;
      BK_ARTIST: if (oslot && pv && idx == sep_at) state_next = BK_TITLE;
      BK_TITLE: if (oslot && pv && idx == kept_count) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // on an output stall keep re-reading the character that waits
  always_comb begin
    t_ra = idx;
    if ((state == BK_ARTIST || state == BK_TITLE) && pv && !oslot) t_ra = idx - AW'(1);
    s_we = (state == BK_COPY) && pv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      title_count <= '0;
      kept_count <= '0;
      shown_count <= '0;
      full <= 1'b0;
      done_cap <= 1'b0;
      idx <= '0;
      pv <= 1'b0;
      sep_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      state <= state_next;
      case (state)
        BK_IDLE: begin
          idx <= '0;
          pv <= 1'b0;
          if (cmd_valid) begin
            case (cmd.op)
              OP_APPEND:
                if (!done_cap) begin
                  if (cmd.data == 8'h00 || full) done_cap <= 1'b1;
                  else begin
                    title_count <= title_count + AW'(1);
                    full <= title_count + AW'(1) == CAP;
                    if (ch != " " && ch != "?") kept_count <= title_count + AW'(1);
                  end
                end
              OP_CLEAR, OP_FINISH:
                if (state_next == BK_IDLE) begin
                  title_count <= '0; kept_count <= '0; full <= 1'b0; done_cap <= 1'b0;
                end
              default: ;
            endcase
          end
        end
        BK_CMP: begin
          idx <= idx + AW'(1);
          pv <= 1'b1;
          if (state_next == BK_IDLE) begin
            title_count <= '0; kept_count <= '0; full <= 1'b0; done_cap <= 1'b0;
          end
          if (state_next != BK_CMP) begin
            idx <= '0; pv <= 1'b0;
          end
        end
        BK_COPY: begin
          idx <= idx + AW'(1);
          pv <= idx < kept_count;
          if (state_next != BK_COPY) begin
            shown_count <= kept_count;
            idx <= '0; pv <= 1'b0; sep_found <= 1'b0;
            p1 <= 8'h00; p2 <= 8'h00;
          end
        end
        BK_SEP: begin
          if (!sep_found && idx != kept_count) begin
            idx <= idx + AW'(1);
            pv <= 1'b1;
            if (pv) begin
              p2 <= p1; p1 <= t_rd;
              if (idx >= AW'(3) && p1 == "-" && p2 == " " && t_rd == " ") begin
                sep_found <= 1'b1; sep_at <= idx - AW'(3);
              end
            end
          end
          if (state_next != BK_SEP) begin
            idx <= (state_next == BK_TITLE) ? AW'(3) : '0; pv <= 1'b0;
          end
          if (state_next == BK_DASH) idx <= '0;
        end
        BK_DASH: if (oslot) begin
          out_valid <= 1'b1; out_kind <= KIND_ARTIST; out_data <= "-"; out_last <= 1'b0;
        end
        BK_ARTIST, BK_TITLE: if (oslot) begin
          pv <= 1'b1;
          idx <= idx + AW'(1);
          if (pv) begin
            out_valid <= 1'b1;
            out_kind <= (state == BK_ARTIST) ? KIND_ARTIST : KIND_TITLE;
            out_data <= t_rd;
            out_last <= (state == BK_TITLE) && idx == kept_count;
          end
          if (state == BK_ARTIST && pv && idx == sep_at) begin
            idx <= sep_at + AW'(3); pv <= 1'b0;
          end
          if (state_next == BK_IDLE) begin
            title_count <= '0; kept_count <= '0; full <= 1'b0; done_cap <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state == BK_IDLE && cmd_valid && cmd.op == OP_AUDIO && oslot) begin
        out_valid <= 1'b1; out_kind <= KIND_AUDIO; out_data <= cmd.data; out_last <= 1'b1;
      end
    end
  end
endmodule

@@ sv/icy_metadata_demuxer_unit_checker.sv @@
// Port-level checker for the ICY metadata demuxer, bound to the top level.
// Depends on icy_pkg and icy_metadata_demuxer_unit_assert.svh.
`include "icy_metadata_demuxer_unit_assert.svh"
module icy_metadata_demuxer_unit_checker
  import icy_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data,
  input logic       out_last
);
  `ICY_ASSERT_RST(a_pready, pready)
  `ICY_ASSERT_CLK(a_kind, out_valid |-> out_kind <= KIND_TITLE)
  `ICY_ASSERT_CLK(a_audio_last, out_valid && out_kind == KIND_AUDIO |-> out_last)
  `ICY_ASSERT_CLK(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
endmodule

bind icy_metadata_demuxer_unit icy_metadata_demuxer_unit_checker u_chk (
  .clk(clk), .rst(rst), .pready(pready), .out_valid(out_valid), .out_ready(out_ready),
  .out_kind(out_kind), .out_data(out_data), .out_last(out_last));

@@ tb/sv/icy_metadata_demuxer_unit_tb.sv @@
// Testbench for icy_metadata_demuxer_unit: random and directed ICY streams,
// a built-in predictor of audio pass-through and title emission, in-order checking.
// Depends on icy_pkg and the icy_metadata_demuxer_unit RTL.
module icy_metadata_demuxer_unit_tb;
  import icy_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TITLE = 63;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [1:0] ADDR_META_INTERVAL = 2'd0;
  localparam string STREAM_KEY = "StreamTitle=";

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } demux_res_t;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [7:0] byte_in = '0;
  logic out_valid, out_ready = 1'b0, out_last;
  logic [1:0] out_kind;
  logic [7:0] out_data;

  icy_metadata_demuxer_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stream predictor state
  logic [15:0] interval_reg, audio_left;
  sec_t        sec;
  int          meta_left, key_pos, value_len, kept_len, shown_len;
  phase_t      phase;
  logic [7:0]  quote_ch;
  logic        quote_held;
  logic [7:0]  title_buf[MAX_TITLE];
  logic [7:0]  shown_buf[MAX_TITLE];

  demux_res_t expected_q[$];
  logic [7:0] stream_q[$];
  int idle_pct = 0, stall_pct = 0;
  bit hold_stream = 1'b0;
  int errors = 0, cycles = 0, bytes_sent = 0, results_seen = 0, titles_shown = 0;
  int blocks_built = 0;

  function automatic void clear_parse();
    key_pos = 0; phase = PH_SEEK; quote_ch = 8'h00; quote_held = 1'b0;
    value_len = 0; kept_len = 0;
  endfunction

  function automatic void add_char(logic [7:0] c);
    logic [7:0] ch;
    if (phase != PH_CAPTURE) return;
    if (c == 8'h00 || value_len >= MAX_TITLE) begin
      phase = PH_DONE;
      return;
    end
    ch = (c >= 8'h20 && c < 8'h7F) ? c : "?";
    title_buf[value_len] = ch;
    value_len++;
    if (ch != " " && ch != "?") kept_len = value_len;
  endfunction

  function automatic void capture_char(logic [7:0] c);
    if (quote_ch != 8'h00) begin
      if (quote_held) begin
        quote_held = 1'b0;
        if (c == ";") begin
          phase = PH_DONE;
          return;
        end
        add_char(quote_ch);
        if (phase != PH_CAPTURE) return;
      end
      if (c == quote_ch) quote_held = 1'b1;
      else add_char(c);
    end else if (c == ";") begin
      phase = PH_DONE;
    end else begin
      add_char(c);
    end
  endfunction

  function automatic void emit_title();
    int diff, sep, first;
    quote_held = 1'b0;
    if (phase == PH_SEEK || kept_len == 0) return;
    diff = 0;
    while (diff < kept_len && diff < shown_len && title_buf[diff] == shown_buf[diff]) diff++;
    if (kept_len == shown_len && diff == kept_len) return;
    for (int i = 0; i < kept_len; i++) shown_buf[i] = title_buf[i];
    shown_len = kept_len;
    titles_shown++;
    sep = -1;
    for (int i = 0; i + 2 < kept_len; i++) begin
      if (title_buf[i] == " " && title_buf[i+1] == "-" && title_buf[i+2] == " ") begin
        sep = i;
        break;
      end
    end
    if (sep < 0) begin
      expected_q.push_back('{KIND_ARTIST, "-", 1'b0});
      first = 0;
    end else begin
      for (int i = 0; i < sep; i++) expected_q.push_back('{KIND_ARTIST, title_buf[i], 1'b0});
      first = sep + 3;
    end
    for (int i = first; i < kept_len; i++)
      expected_q.push_back('{KIND_TITLE, title_buf[i], logic'(i + 1 == kept_len)});
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    if (interval_reg == 0) begin
      expected_q.push_back('{KIND_AUDIO, c, 1'b1});
      return;
    end
    if (sec == SEC_AUDIO && audio_left == 0) sec = SEC_LEN;
    if (sec == SEC_AUDIO) begin
      expected_q.push_back('{KIND_AUDIO, c, 1'b1});
      audio_left--;
      if (audio_left == 0) sec = SEC_LEN;
      return;
    end
    if (sec == SEC_LEN) begin
      meta_left = int'(c) * 16;
      clear_parse();
      if (meta_left == 0) begin
        audio_left = interval_reg;
        sec = SEC_AUDIO;
      end else begin
        sec = SEC_BODY;
      end
      return;
    end
    case (phase)
      PH_SEEK: begin
        if (key_pos < 12 && c == STREAM_KEY[key_pos]) key_pos++;
        else key_pos = (c == STREAM_KEY[0]) ? 1 : 0;
        if (key_pos >= 12) phase = PH_FIRST;
      end
      PH_FIRST: begin
        phase = PH_CAPTURE;
        if (c == "'" || c == "\"") quote_ch = c;
        else begin
          quote_ch = 8'h00;
          capture_char(c);
        end
      end
      PH_CAPTURE: capture_char(c);
      default: ;
    endcase
    if (meta_left > 0) meta_left--;
    if (meta_left != 0) return;
    emit_title();
    clear_parse();
    audio_left = interval_reg;
    sec = SEC_AUDIO;
  endfunction

  // sender
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(byte_in);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() > 0 && !hold_stream && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          byte_in <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    demux_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: kind %0d data %02h last %0b",
                     out_kind, out_data, out_last);
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind || out_data !== want.data || out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected kind %0d data %02h last %0b, got %0d %02h %0b",
                       want.kind, want.data, want.last, out_kind, out_data, out_last);
          end
        end
      end
      out_ready <= (stall_pct > 0 && $urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic settle();
    wait (stream_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_META_INTERVAL; pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    interval_reg = value; audio_left = value; sec = SEC_AUDIO; meta_left = 0;
    clear_parse();
  endtask

  task automatic push_audio(int n);
    repeat (n) stream_q.push_back(8'($urandom));
  endtask

  // one metadata block after the audio run; lblocks < 0 picks the smallest fit
  task automatic push_block(int audio_n, string body, int lblocks, bit rand_pad);
    int len;
    push_audio(audio_n);
    len = (lblocks < 0) ? (body.len() + 15) / 16 : lblocks;
    stream_q.push_back(8'(len));
    for (int i = 0; i < len * 16; i++)
      stream_q.push_back(i < body.len() ? body[i] : (rand_pad ? 8'($urandom) : 8'h00));
    blocks_built++;
  endtask

  function automatic string random_value(ref string recent[$]);
    string s;
    int n;
    if (recent.size() > 0 && $urandom_range(3) == 0) return recent[$urandom_range(recent.size()-1)];
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 14);
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: s = {s, " - "};
        1: s = {s, " "};
        2: s = {s, string'(8'($urandom_range(1, 255)))};
        default: s = {s, string'(8'($urandom_range(8'h41, 8'h5A)))};
      endcase
    end
    recent.push_back(s);
    if (recent.size() > 4) void'(recent.pop_front());
    return s;
  endfunction

  task automatic random_stream(int items);
    string recent[$];
    string body, val, q;
    int start;
    start = stream_q.size() + bytes_sent;
    while (stream_q.size() + bytes_sent - start < items) begin
      if (interval_reg == 0 || $urandom_range(9) == 0) begin
        push_audio($urandom_range(1, 6));
        continue;
      end
      val = random_value(recent);
      case ($urandom_range(2))
        0: q = "'";
        1: q = "\"";
        default: q = "";
      endcase
      body = ($urandom_range(4) == 0) ? "junk;Stream" : "";
      if ($urandom_range(9) != 0) body = {body, STREAM_KEY};
      else body = {body, "StreamTitl="};
      body = {body, q, val};
      if ($urandom_range(5) != 0) body = {body, q, ";"};
      push_block(interval_reg, body,
                 ($urandom_range(11) == 0) ? $urandom_range(0, 2) : -1,
                 $urandom_range(1) == 1);
    end
  endtask

  initial begin
    string long_val;
    clear_parse();
    interval_reg = '0; audio_left = '0; sec = SEC_AUDIO; meta_left = 0; shown_len = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_interval(16'd0);
    stream_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01};
    settle();
    write_interval(16'hFFFF);
    push_audio(3);
    settle();

    write_interval(16'd1);
    push_block(1, "", 0, 1'b0);
    push_block(1, "StreamTitle='Band - Song';", -1, 1'b1);
    push_block(1, "StreamTitle='Band - Song';", -1, 1'b1);
    push_block(1, "x;StreamTitle=\"it's - a\";", -1, 1'b1);
    push_block(1, "StreamTitle= - Solo;", -1, 1'b1);
    push_block(1, string'({"StreamTitle=ab", 8'h7F, 8'h1F, 8'hFF, "c;"}), -1, 1'b0);
    push_block(1, "StreamTitle='Nul", -1, 1'b0);
    push_block(1, "StreamTitle='Trail  ?? ';", -1, 1'b1);
    push_block(1, "StreamTitle='   ';", -1, 1'b1);
    push_block(1, "NoKeyHere='x';", -1, 1'b1);
    push_block(1, "StreamTitle='EndQ'", 2, 1'b0);
    push_block(1, "StreamTitle='Ed'", -1, 1'b0);
    long_val = "";
    for (int i = 0; i < 70; i++) long_val = {long_val, string'(8'h41 + 8'(i % 26))};
    push_block(1, {"StreamTitle=", long_val}, -1, 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  write_interval(16'd2); end
        1: begin idle_pct = 55; stall_pct = 0;  write_interval(16'd0); end
        2: begin idle_pct = 0;  stall_pct = 55; write_interval(16'd5); end
        default: begin idle_pct = 38; stall_pct = 38; write_interval(16'd1); end
      endcase
      random_stream(20);
      if (ph == 1) begin
        settle();
        write_interval(16'd3);
        random_stream(10);
      end
      if (ph == 2) begin
        wait (stream_q.size() == 0 && !in_valid);
        hold_stream = 1'b1;
        random_stream(15);
        wait (expected_q.size() == 0);
        hold_stream = 1'b0;
      end
      settle();
    end

    $display("covered %0d stream bytes, %0d metadata blocks, %0d output transfers",
             bytes_sent, blocks_built, results_seen);
    $display("titles emitted %0d, mismatches %0d", titles_shown, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/icy_pkg.sv
sv/icy_ram.sv
sv/icy_front.sv
sv/icy_back.sv
sv/icy_metadata_demuxer_unit.sv
sv/icy_metadata_demuxer_unit_checker.sv
tb/sv/icy_metadata_demuxer_unit_tb.sv
